/* src/sorted_insert_priority_queue_assert.svh */
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SIPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SIPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/sipq_pkg.sv */
package sipq_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int TAG_W = 16;
  localparam int PRI_W = 8;

  typedef enum logic [1:0] {
    STATUS_INSERTED,
    STATUS_REMOVED,
    STATUS_FULL,
    STATUS_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_WRITE_NEW,
    ST_REM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] pri;
  } entry_t;

endpackage

/* src/sipq_ram.sv */
module sipq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sorted_insert_priority_queue.sv */
// Priority queue of up to DEPTH entries (tag, priority), served highest priority first and
// in arrival order among equal priorities. Entries sit in one RAM used as a ring from a head
// pointer, kept sorted. Each request on the s_axis side (tuser 0 insert, 1 remove) gives one
// result on the m_axis side. A remove reads the head, registers the result and hands it
// off. An insert shifts back each stored entry of lower priority, then writes the new one:
// the RAM moves one of them back by one slot per cycle, a read of the next entry overlapping
// the write of the current one. A refused request goes straight to the hand-off.
// The next request is taken while a finished result still waits in the output register.
// No clearing pass is needed after reset.
module sorted_insert_priority_queue #(
  parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // entry_tag[15:0], entry_priority[23:16]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // head_tag[15:0], head_priority[23:16]
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int EW = $bits(sipq_pkg::entry_t);

  sipq_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [AW-1:0] head;
  sipq_pkg::entry_t new_entry;
  sipq_pkg::status_t res_status;
  sipq_pkg::entry_t res_entry;

  sipq_pkg::status_t out_status;
  sipq_pkg::entry_t out_entry;
  logic out_valid;

  logic accept;
  logic is_remove;
  logic full;
  logic empty;
  logic move;
  logic out_free;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  sipq_pkg::entry_t ram_wdata;
  sipq_pkg::entry_t ram_rdata;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] rel);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + SW'(rel);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_remove = s_axis_tuser;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign move      = (ram_rdata.pri < new_entry.pri);
  assign out_free  = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == sipq_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_entry.pri, out_entry.tag};
  assign m_axis_tuser  = out_status;

  sipq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      sipq_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_remove) begin
            state_next = empty ? sipq_pkg::ST_DONE : sipq_pkg::ST_REM;
          end else if (full) begin
            state_next = sipq_pkg::ST_DONE;
          end else begin
            state_next = empty ? sipq_pkg::ST_WRITE_NEW : sipq_pkg::ST_SHIFT;
          end
        end
      end
      sipq_pkg::ST_SHIFT: begin
        if (!move) begin
          state_next = sipq_pkg::ST_DONE;
        end else if (pos == CW'(1)) begin
          state_next = sipq_pkg::ST_WRITE_NEW;
        end
      end
      sipq_pkg::ST_WRITE_NEW: state_next = sipq_pkg::ST_DONE;
      sipq_pkg::ST_REM:       state_next = sipq_pkg::ST_DONE;
      sipq_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sipq_pkg::ST_IDLE;
        end
      end
      default: state_next = sipq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wrap_addr(head, pos);
    ram_wdata = new_entry;
    ram_raddr = head;
    case (state)
      sipq_pkg::ST_IDLE: begin
        if (accept && !is_remove && !empty) begin
          ram_raddr = wrap_addr(head, count - CW'(1));
        end
      end
      sipq_pkg::ST_SHIFT: begin
        ram_we = 1'b1;
        if (move) begin
          ram_wdata = ram_rdata;
          ram_raddr = wrap_addr(head, pos - CW'(2));
        end
      end
      sipq_pkg::ST_WRITE_NEW: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sipq_pkg::ST_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        sipq_pkg::ST_SHIFT: begin
          if (!move) begin
            count <= count + CW'(1);
          end
        end
        sipq_pkg::ST_WRITE_NEW: count <= count + CW'(1);
        sipq_pkg::ST_REM: begin
          count <= count - CW'(1);
          head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        end
        default: ;
      endcase
      if (state == sipq_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sipq_pkg::ST_IDLE: begin
        if (accept) begin
          new_entry.tag <= s_axis_tdata[15:0];
          new_entry.pri <= s_axis_tdata[23:16];
          pos           <= count;
          res_entry     <= '0;
          if (is_remove) begin
            res_status <= sipq_pkg::STATUS_EMPTY;
          end else begin
            res_status <= full ? sipq_pkg::STATUS_FULL : sipq_pkg::STATUS_INSERTED;
          end
        end
      end
      sipq_pkg::ST_SHIFT: begin
        if (move) begin
          pos <= pos - CW'(1);
        end
      end
      sipq_pkg::ST_REM: begin
        res_status <= sipq_pkg::STATUS_REMOVED;
        res_entry  <= ram_rdata;
      end
      sipq_pkg::ST_DONE: begin
        if (out_free) begin
          out_status <= res_status;
          out_entry  <= res_entry;
        end
      end
      default: ;
    endcase
  end

`include "sorted_insert_priority_queue_assert.svh"

  `SIPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `SIPQ_ASSERT_NOW(a_shift_pos, state == sipq_pkg::ST_SHIFT, pos != '0, "shift at slot zero")
  `SIPQ_ASSERT_NOW(a_zero_data, m_axis_tvalid && m_axis_tuser != sipq_pkg::STATUS_REMOVED,
    m_axis_tdata == '0, "nonzero data on non-remove result")
  `SIPQ_ASSERT_NEXT(a_remove_path, accept && is_remove && !empty,
    state == sipq_pkg::ST_REM, "remove of live entry skipped head read")
  `SIPQ_ASSERT_NEXT(a_full_hold, accept && !is_remove && full,
    count == $past(count), "refused insert changed entry count")

endmodule
